[design/led_matrix_pixel_index_map_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the LED matrix pixel index map.
// Each macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_PIXEL_INDEX_MAP_ASSERT_SVH
`define LED_MATRIX_PIXEL_INDEX_MAP_ASSERT_SVH

// Same-cycle implication
`define LPIM_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LPIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lpim_pkg.sv]
// ----------------------------------------------------------------------------
// lpim_pkg
// Shared widths, register indexes, layout codes and types of the LED matrix
// pixel index map.
// ----------------------------------------------------------------------------
package lpim_pkg;

	// Field widths
	localparam int COORD_W   = 6;
	localparam int CFG_W     = 7;
	localparam int MODE_W    = 3;
	localparam int IDX_W     = 12;
	localparam int ST_W      = 2;
	localparam int REG_IDX_W = 3;

	// Largest legal display or panel dimension
	localparam int MAX_DIM = 64;
	// Largest chain position
	localparam int IDX_MAX = 4095;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_LAYOUT_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH_PIXELS  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT_PIXELS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd4;

	// Layout codes
	localparam logic [MODE_W-1:0] LM_RING   = 3'd1;
	localparam logic [MODE_W-1:0] LM_STRAND = 3'd2;
	localparam logic [MODE_W-1:0] LM_PANEL  = 3'd3;
	localparam logic [MODE_W-1:0] LM_MULTI  = 3'd4;

	// Reset values of the registers
	localparam logic [MODE_W-1:0] RST_LAYOUT_MODE   = LM_RING;
	localparam logic [CFG_W-1:0]  RST_WIDTH_PIXELS  = 7'd12;
	localparam logic [CFG_W-1:0]  RST_HEIGHT_PIXELS = 7'd1;
	localparam logic [CFG_W-1:0]  RST_TILE_WIDTH    = 7'd8;
	localparam logic [CFG_W-1:0]  RST_TILE_HEIGHT   = 7'd8;

	// Result status
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_GEOM  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Derived tile geometry sequencer
	typedef enum logic [2:0] {
		SEQ_LOAD,
		SEQ_DIV,
		SEQ_MUL1,
		SEQ_MUL2,
		SEQ_BASE,
		SEQ_DONE
	} seq_state_t;

endpackage

[design/lpim_pix_if.sv]
// ----------------------------------------------------------------------------
// lpim_pix_if
// Pixel coordinate channel: valid/ready with one (col_x, row_y) per transfer.
// ----------------------------------------------------------------------------
interface lpim_pix_if;
	logic                         valid;
	logic                         ready;
	logic [lpim_pkg::COORD_W-1:0] col_x;
	logic [lpim_pkg::COORD_W-1:0] row_y;

	modport source (output valid, output col_x, output row_y, input ready);
	modport sink (input valid, input col_x, input row_y, output ready);
endinterface

[design/lpim_res_if.sv]
// ----------------------------------------------------------------------------
// lpim_res_if
// Result channel: valid/ready with one chain index and status per transfer.
// ----------------------------------------------------------------------------
interface lpim_res_if;
	logic                       valid;
	logic                       ready;
	logic [lpim_pkg::IDX_W-1:0] chain_index;
	logic [lpim_pkg::ST_W-1:0]  status;

	modport source (output valid, output chain_index, output status, input ready);
	modport sink (input valid, input chain_index, input status, output ready);
endinterface

[design/lpim_cfg_if.sv]
// ----------------------------------------------------------------------------
// lpim_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface lpim_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lpim_pkg::REG_IDX_W-1:0] index;
	logic [lpim_pkg::CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/led_matrix_pixel_index_map.sv]
// ----------------------------------------------------------------------------
// led_matrix_pixel_index_map: four-stage pipeline, one pixel per clock unless stalled.
// A full output register that is not taken stalls all stages; input ready follows the last
// stage. After reset and after every register write, input holds off while the tile
// sequencer redoes its divisions and products; reset restores defaults.
// ----------------------------------------------------------------------------
module led_matrix_pixel_index_map (
	input  logic       clk,
	input  logic       arst_n,
	lpim_pix_if.sink   pixel,
	lpim_res_if.source result,
	lpim_cfg_if.sink   cfg
);
	import lpim_pkg::*;

	`include "led_matrix_pixel_index_map_assert.svh"

	localparam int DIV_STEPS = CFG_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int HALF_Q    = COORD_W / 2;
	localparam int ROWPX_W   = 2 * COORD_W + 1;
	localparam int PROD_W    = CFG_W + ROWPX_W;
	localparam int P_W       = PROD_W + 2;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [MODE_W-1:0] mode_q;
	logic [CFG_W-1:0]  w_q;
	logic [CFG_W-1:0]  h_q;
	logic [CFG_W-1:0]  tw_q;
	logic [CFG_W-1:0]  th_q;
	logic              cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// Decode the register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RST_LAYOUT_MODE;
			w_q    <= RST_WIDTH_PIXELS;
			h_q    <= RST_HEIGHT_PIXELS;
			tw_q   <= RST_TILE_WIDTH;
			th_q   <= RST_TILE_HEIGHT;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_LAYOUT_MODE:   mode_q <= cfg.data[MODE_W-1:0];
				REG_WIDTH_PIXELS:  w_q    <= cfg.data;
				REG_HEIGHT_PIXELS: h_q    <= cfg.data;
				REG_TILE_WIDTH:    tw_q   <= cfg.data;
				REG_TILE_HEIGHT:   th_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Tile geometry sequencer: tiles across, tiles down, pixels per
	// tile row and the chain position of the top-left pixel
	// ------------------------------------------------------------------
	seq_state_t         seq_state_q;
	seq_state_t         seq_state_nx;
	logic [CNT_W-1:0]   cnt_q;
	logic [CFG_W-1:0]   wq_q;
	logic [CFG_W-1:0]   wr_q;
	logic [CFG_W-1:0]   hq_q;
	logic [CFG_W-1:0]   hr_q;
	logic [CFG_W-1:0]   twxt_q;
	logic [ROWPX_W-1:0] row_px_q;
	logic [ROWPX_W-1:0] base_q;
	logic [CFG_W:0]     w_sh;
	logic [CFG_W:0]     h_sh;
	logic               w_ge;
	logic               h_ge;
	logic               seq_done;

	assign seq_done = (seq_state_q == SEQ_DONE);

	// Next state; a register write restarts the sequence
	always_comb begin
		seq_state_nx = seq_state_q;
		case (seq_state_q)
			SEQ_LOAD: seq_state_nx = SEQ_DIV;
			SEQ_DIV:  seq_state_nx = (cnt_q == CNT_W'(DIV_STEPS - 1)) ? SEQ_MUL1 : SEQ_DIV;
			SEQ_MUL1: seq_state_nx = SEQ_MUL2;
			SEQ_MUL2: seq_state_nx = SEQ_BASE;
			SEQ_BASE: seq_state_nx = SEQ_DONE;
			SEQ_DONE: seq_state_nx = SEQ_DONE;
			default:  seq_state_nx = SEQ_LOAD;
		endcase
		if (cfg_wr) begin
			seq_state_nx = SEQ_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_state_q <= SEQ_LOAD;
			cnt_q       <= '0;
		end else begin
			seq_state_q <= seq_state_nx;
			cnt_q       <= (seq_state_q == SEQ_DIV) ? cnt_q + 1'b1 : '0;
		end
	end

	// One restoring division step for each of the two quotients
	always_comb begin
		w_sh = {wr_q, wq_q[CFG_W-1]};
		h_sh = {hr_q, hq_q[CFG_W-1]};
		w_ge = (w_sh >= {1'b0, tw_q});
		h_ge = (h_sh >= {1'b0, th_q});
	end

	always_ff @(posedge clk) begin
		case (seq_state_q)
			SEQ_LOAD: begin
				wq_q <= w_q;
				wr_q <= '0;
				hq_q <= h_q;
				hr_q <= '0;
			end
			SEQ_DIV: begin
				wq_q <= {wq_q[CFG_W-2:0], w_ge};
				wr_q <= w_ge ? CFG_W'(w_sh - {1'b0, tw_q}) : w_sh[CFG_W-1:0];
				hq_q <= {hq_q[CFG_W-2:0], h_ge};
				hr_q <= h_ge ? CFG_W'(h_sh - {1'b0, th_q}) : h_sh[CFG_W-1:0];
			end
			SEQ_MUL1: twxt_q   <= CFG_W'(tw_q * wq_q);
			SEQ_MUL2: row_px_q <= ROWPX_W'(ROWPX_W'(twxt_q) * ROWPX_W'(th_q));
			SEQ_BASE: begin
				base_q <= ROWPX_W'(PROD_W'(row_px_q) * PROD_W'(CFG_W'(hq_q - 1'b1))
					+ PROD_W'(th_q) - PROD_W'(1));
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control: every stage advances unless the result waits
	// ------------------------------------------------------------------
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic adv;
	logic pix_xfer;

	assign adv         = !vld_s4 || result.ready;
	assign pixel.ready = adv && seq_done;
	assign pix_xfer    = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_xfer;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: geometry and coordinate checks, upper quotient bits of row / tile_height
	// ------------------------------------------------------------------
	logic               dim_bad_h;
	logic               dim_bad_tw;
	logic               dim_bad_th;
	logic               geom_bad;
	logic               coord_bad;
	logic [CFG_W-1:0]   d1_rem;
	logic [CFG_W:0]     d1_sh;
	logic [HALF_Q-1:0]  d1_q;
	status_t            st1;

	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [CFG_W-1:0]   rem_s1;
	logic [HALF_Q-1:0]  q_s1;
	status_t            st_s1;

	always_comb begin
		dim_bad_h  = (h_q == '0) || (int'(h_q) > MAX_DIM);
		dim_bad_tw = (tw_q == '0) || (int'(tw_q) > MAX_DIM);
		dim_bad_th = (th_q == '0) || (int'(th_q) > MAX_DIM);
		geom_bad   = (mode_q < LM_RING) || (mode_q > LM_MULTI)
			|| (int'(w_q) > MAX_DIM) || dim_bad_h
			|| (((mode_q == LM_RING) || (mode_q == LM_STRAND)) && (h_q != CFG_W'(1)))
			|| ((mode_q == LM_PANEL) && (h_q == CFG_W'(1)))
			|| ((mode_q == LM_MULTI) && (dim_bad_tw || dim_bad_th
				|| (h_q < th_q) || (w_q < tw_q)));
		coord_bad  = ({1'b0, pixel.col_x} >= w_q) || ({1'b0, pixel.row_y} >= h_q);
		if (geom_bad) begin
			st1 = ST_GEOM;
		end else if (coord_bad) begin
			st1 = ST_RANGE;
		end else begin
			st1 = ST_OK;
		end

		// Restoring division, top half of the quotient bits
		d1_rem = '0;
		d1_sh  = '0;
		d1_q   = '0;
		for (int i = 0; i < HALF_Q; i++) begin
			d1_sh = {d1_rem, pixel.row_y[COORD_W-1-i]};
			if (d1_sh >= {1'b0, th_q}) begin
				d1_rem             = CFG_W'(d1_sh - {1'b0, th_q});
				d1_q[HALF_Q-1-i]   = 1'b1;
			end else begin
				d1_rem = d1_sh[CFG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= pixel.col_x;
			y_s1   <= pixel.row_y;
			rem_s1 <= d1_rem;
			q_s1   <= d1_q;
			st_s1  <= st1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: lower quotient bits, tile_width * x, multiplier operands
	// ------------------------------------------------------------------
	localparam int LOW_Q = COORD_W - HALF_Q;

	logic [CFG_W-1:0]   d2_rem;
	logic [CFG_W:0]     d2_sh;
	logic [LOW_Q-1:0]   d2_q;
	logic [COORD_W-1:0] rn;
	logic [CFG_W-1:0]   my;
	logic [CFG_W-1:0]   mx;

	logic [CFG_W-1:0]   a_s2;
	logic [ROWPX_W-1:0] b_s2;
	logic [ROWPX_W-1:0] twx_s2;
	logic [CFG_W-1:0]   py_s2;
	logic [CFG_W-1:0]   col_s2;
	status_t            st_s2;

	always_comb begin
		d2_rem = rem_s1;
		d2_sh  = '0;
		d2_q   = '0;
		for (int i = 0; i < LOW_Q; i++) begin
			d2_sh = {d2_rem, y_s1[LOW_Q-1-i]};
			if (d2_sh >= {1'b0, th_q}) begin
				d2_rem           = CFG_W'(d2_sh - {1'b0, th_q});
				d2_q[LOW_Q-1-i]  = 1'b1;
			end else begin
				d2_rem = d2_sh[CFG_W-1:0];
			end
		end
		rn = {q_s1, d2_q};
		// Mirrored coordinate of the single-panel layout
		my = CFG_W'(h_q - 1'b1 - {1'b0, y_s1});
		mx = CFG_W'(w_q - 1'b1 - {1'b0, x_s1});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (mode_q)
				LM_MULTI: begin
					a_s2 <= {1'b0, rn};
					b_s2 <= row_px_q;
				end
				LM_PANEL: begin
					a_s2 <= my;
					b_s2 <= ROWPX_W'(w_q);
				end
				default: begin
					a_s2 <= {1'b0, y_s1};
					b_s2 <= ROWPX_W'(w_q);
				end
			endcase
			twx_s2 <= ROWPX_W'(ROWPX_W'(tw_q) * ROWPX_W'(x_s1));
			py_s2  <= d2_rem;
			// Odd mirrored rows take the mirrored column, even rows fall back to x
			col_s2 <= ((mode_q == LM_PANEL) && my[0]) ? mx : {1'b0, x_s1};
			st_s2  <= st_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: row product and column term
	// ------------------------------------------------------------------
	logic [PROD_W-1:0]     prod_s3;
	logic signed [P_W-1:0] col_s3;
	logic                  neg_s3;
	status_t               st_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= PROD_W'(PROD_W'(a_s2) * PROD_W'(b_s2));
			if (mode_q == LM_MULTI) begin
				col_s3 <= $signed(P_W'(base_q)) + $signed(P_W'(twx_s2))
					- $signed(P_W'(py_s2));
			end else begin
				col_s3 <= $signed(P_W'(col_s2));
			end
			neg_s3 <= (mode_q == LM_MULTI);
			st_s3  <= st_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: combine, range check, output register
	// ------------------------------------------------------------------
	logic signed [P_W-1:0] p_full;
	logic                  p_out;
	status_t               st4;

	logic [IDX_W-1:0]      index_s4;
	status_t               status_s4;

	always_comb begin
		if (neg_s3) begin
			p_full = col_s3 - $signed(P_W'(prod_s3));
		end else begin
			p_full = col_s3 + $signed(P_W'(prod_s3));
		end
		p_out = (p_full < $signed(P_W'(0))) || (p_full > $signed(P_W'(IDX_MAX)));
		st4   = ((st_s3 == ST_OK) && p_out) ? ST_RANGE : st_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			index_s4  <= (st4 == ST_OK) ? p_full[IDX_W-1:0] : '0;
			status_s4 <= st4;
		end
	end

	assign result.valid       = vld_s4;
	assign result.chain_index = index_s4;
	assign result.status      = status_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`LPIM_ASSERT_IMPLY(a_bad_status_zero_index, vld_s4 && (status_s4 != ST_OK), index_s4 == '0, "index not zero on failed status")
	`LPIM_ASSERT_NEXT(a_cfg_restarts_seq, cfg_wr, seq_state_q == SEQ_LOAD, "register write did not restart tile sequencer")
	`LPIM_ASSERT_NEXT(a_xfer_fills_s1, pix_xfer, vld_s1, "accepted pixel missing from stage 1")
	`LPIM_ASSERT_NEXT(a_stall_holds_s3, vld_s3 && !adv, vld_s3 && $stable(prod_s3), "stage 3 lost data during stall")

endmodule
